FILE: rtl/core/octc_pkg.sv
// Shared types and constants for the oven cook-timer controller.
// No dependencies; imported by octc_div and oven_cook_timer_controller.
package octc_pkg;

    // divider operand width (tick and second counters are 16 bits)
    localparam int DIV_W = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int LED_COUNT_DEF = 8;

    // event kinds
    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_KNOB   = 3'd1;
    localparam logic [2:0] FUNC_B3_DN  = 3'd2;
    localparam logic [2:0] FUNC_B3_UP  = 3'd3;
    localparam logic [2:0] FUNC_B4_DN  = 3'd4;
    localparam logic [2:0] FUNC_B4_UP  = 3'd5;

    // controller states
    localparam logic [1:0] ST_SETUP  = 2'd0;
    localparam logic [1:0] ST_SELECT = 2'd1;
    localparam logic [1:0] ST_COOK   = 2'd2;
    localparam logic [1:0] ST_RESETP = 2'd3;

    // cook modes
    localparam logic [1:0] MODE_BAKE  = 2'd0;
    localparam logic [1:0] MODE_TOAST = 2'd1;
    localparam logic [1:0] MODE_BROIL = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TPS        = 2'd0;
    localparam logic [1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [1:0] CFG_BAKE_OFS   = 2'd2;
    localparam logic [1:0] CFG_BROIL_TEMP = 2'd3;

    // divider handshake
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } octc_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] remainder;
    } octc_div_rsp_t;

endpackage

FILE: rtl/core/octc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on octc_pkg for operand width and request/response structs.
module octc_div
    import octc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  octc_div_req_t req,
    output octc_div_rsp_t rsp
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     dsr_reg;

    logic [DIV_W:0] shifted;
    logic [DIV_W:0] trial;

    always_comb begin
        shifted = {rem_reg, quo_reg[DIV_W-1]};
        trial   = shifted - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end else if (busy_reg) begin
            // borrow in the top bit means the trial subtract failed
            if (trial[DIV_W]) begin
                rem_reg <= shifted[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end else begin
                rem_reg <= trial[DIV_W-1:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: rtl/core/oven_cook_timer_controller.sv
// Oven cook-timer controller top level: event sequencer, state and result register.
// Depends on octc_pkg and octc_div.
//
// Usage: one event request (tick, knob reading, button 3/4 press or release)
// enters on s_valid/s_ready; each request yields exactly one status result on
// m_valid/m_ready. Settings are written through cfg_wr_en/cfg_index/cfg_wdata
// while no request is in flight.
// One request at a time: the next is taken only once the sequencer is idle.
// Knob, button and ordinary tick requests go from the EXEC state straight to
// the OUT state. A tick during a cook runs the shared restoring divider on
// press length mod ticks per second; at a second boundary that does not end
// the cook it runs it once more on elapsed seconds mod (set time / LED count,
// taken by a constant reciprocal multiply), unless that quotient is zero.
// s_ready rises again once the result has moved into the output register, so
// the next request is taken while a result still waits; if the receiver stalls
// longer, the finished result of the following request holds the sequencer
// and s_ready stays low.
// Reset (aresetn, synchronous, active low) restores the default settings and
// puts the oven in setup, bake mode, time selected, set time 1 s.
module oven_cook_timer_controller
    import octc_pkg::*;
#(
    parameter int LED_COUNT = LED_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [9:0]  s_knob_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_oven_state,
    output logic [1:0]  m_cook_mode,
    output logic        m_adjusting_temp,
    output logic [8:0]  m_set_time_s,
    output logic [8:0]  m_remaining_s,
    output logic [10:0] m_temperature_f,
    output logic        m_heater_on,
    output logic [7:0]  m_led_bar
);

    localparam int LED_EXT_W = (LED_COUNT > 8) ? LED_COUNT : 8;

    // set time / LED_COUNT by reciprocal; exact for 9-bit set times
    localparam int         PER_SH    = 13;
    localparam logic [13:0] PER_RECIP = 14'((2 ** PER_SH + LED_COUNT - 1) / LED_COUNT);

    localparam logic [2:0] SEQ_IDLE = 3'd0;
    localparam logic [2:0] SEQ_EXEC = 3'd1;
    localparam logic [2:0] SEQ_TPS  = 3'd2;
    localparam logic [2:0] SEQ_ELAP = 3'd4;
    localparam logic [2:0] SEQ_OUT  = 3'd5;

    // settings
    logic [7:0] tps_reg;
    logic [7:0] long_press_reg;
    logic [9:0] bake_ofs_reg;
    logic [9:0] broil_temp_reg;

    // request holding
    logic [2:0] func_reg;
    logic [9:0] knob_reg;

    // controller state
    logic [2:0]           seq_reg;
    logic [1:0]           ctrl_state_reg;
    logic [1:0]           mode_reg;
    logic                 temp_select_reg;
    logic [8:0]           cook_time_reg;
    logic [7:0]           knob_temp_reg;
    logic [8:0]           time_left_reg;
    logic [15:0]          tick_count_reg;
    logic [15:0]          press_start_reg;
    logic [15:0]          seconds_elapsed_reg;
    logic [LED_COUNT-1:0] led_pattern_reg;

    // result register
    logic        m_valid_reg;
    logic [1:0]  m_oven_state_reg;
    logic [1:0]  m_cook_mode_reg;
    logic        m_adjusting_temp_reg;
    logic [8:0]  m_set_time_s_reg;
    logic [8:0]  m_remaining_s_reg;
    logic [10:0] m_temperature_f_reg;
    logic        m_heater_on_reg;
    logic [7:0]  m_led_bar_reg;

    octc_div_req_t div_req;
    octc_div_rsp_t div_rsp;

    logic [15:0]          tick_inc;
    logic [15:0]          press_len;
    logic [15:0]          press_len_tick;
    logic [7:0]           tps_eff;
    logic                 heating;
    logic                 tick_cancel;
    logic                 tick_countdown;
    logic [8:0]           tl_dec;
    logic [7:0]           knob_q;
    logic [21:0]          per_prod;
    logic [8:0]           per_q;
    logic [10:0]          temp_now;
    logic [LED_EXT_W-1:0] led_ext;
    logic                 out_free;

    octc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        tick_inc       = tick_count_reg + 16'd1;
        press_len      = tick_count_reg - press_start_reg;
        press_len_tick = tick_inc - press_start_reg;
        tps_eff        = (tps_reg == 8'd0) ? 8'd1 : tps_reg;
        heating        = (ctrl_state_reg == ST_COOK) || (ctrl_state_reg == ST_RESETP);
        tick_cancel    = (ctrl_state_reg == ST_RESETP) &&
                         (press_len_tick >= 16'(long_press_reg));
        tick_countdown = (func_reg == FUNC_TICK) && heating && !tick_cancel;
        tl_dec         = (time_left_reg == 9'd0) ? 9'd0 : time_left_reg - 9'd1;
        knob_q         = knob_reg[9:2];
        per_prod       = {13'd0, cook_time_reg} * {8'd0, PER_RECIP};
        per_q          = per_prod[21:13];
        led_ext        = LED_EXT_W'(led_pattern_reg);
        out_free       = !m_valid_reg || m_ready;
        unique case (mode_reg)
            MODE_TOAST: temp_now = 11'd0;
            MODE_BROIL: temp_now = {1'b0, broil_temp_reg};
            default:    temp_now = {3'b000, knob_temp_reg} + {1'b0, bake_ofs_reg};
        endcase
    end

    // divider launch points
    always_comb begin
        div_req = '0;
        unique case (seq_reg)
            SEQ_EXEC: begin
                if (tick_countdown) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = press_len_tick;
                    div_req.divisor  = DIV_W'(tps_eff);
                end
            end
            SEQ_TPS: begin
                if (div_rsp.done && div_rsp.remainder == '0 && tl_dec != 9'd0 &&
                    per_q != 9'd0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = seconds_elapsed_reg + 16'd1;
                    div_req.divisor  = DIV_W'(per_q);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg        <= 8'd5;
            long_press_reg <= 8'd5;
            bake_ofs_reg   <= 10'd300;
            broil_temp_reg <= 10'd500;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_TPS:        tps_reg        <= cfg_wdata[7:0];
                CFG_LONG_PRESS: long_press_reg <= cfg_wdata[7:0];
                CFG_BAKE_OFS:   bake_ofs_reg   <= cfg_wdata;
                CFG_BROIL_TEMP: broil_temp_reg <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            func_reg <= s_func;
            knob_reg <= s_knob_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg             <= SEQ_IDLE;
            ctrl_state_reg      <= ST_SETUP;
            mode_reg            <= MODE_BAKE;
            temp_select_reg     <= 1'b0;
            cook_time_reg       <= 9'd1;
            knob_temp_reg       <= 8'd50;
            time_left_reg       <= 9'd1;
            tick_count_reg      <= '0;
            press_start_reg     <= '0;
            seconds_elapsed_reg <= '0;
            led_pattern_reg     <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (seq_reg == SEQ_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (seq_reg)
                SEQ_IDLE: begin
                    if (s_valid) begin
                        seq_reg <= SEQ_EXEC;
                    end
                end
                SEQ_EXEC: begin
                    seq_reg <= tick_countdown ? SEQ_TPS : SEQ_OUT;
                    unique case (func_reg)
                        FUNC_TICK: begin
                            tick_count_reg <= tick_inc;
                            if (tick_cancel) begin
                                ctrl_state_reg  <= ST_SETUP;
                                led_pattern_reg <= '0;
                            end
                        end
                        FUNC_KNOB: begin
                            if (!temp_select_reg) begin
                                cook_time_reg <= {1'b0, knob_q} + 9'd1;
                            end else begin
                                knob_temp_reg <= knob_q;
                            end
                        end
                        FUNC_B3_DN: begin
                            if (ctrl_state_reg == ST_SETUP) begin
                                press_start_reg <= tick_count_reg;
                                ctrl_state_reg  <= ST_SELECT;
                            end
                        end
                        FUNC_B3_UP: begin
                            if (ctrl_state_reg == ST_SELECT) begin
                                if (press_len < 16'(long_press_reg)) begin
                                    unique case (mode_reg)
                                        MODE_BAKE:  mode_reg <= MODE_TOAST;
                                        MODE_TOAST: mode_reg <= MODE_BROIL;
                                        default:    mode_reg <= MODE_BAKE;
                                    endcase
                                end else if (mode_reg == MODE_BAKE) begin
                                    temp_select_reg <= !temp_select_reg;
                                end
                                ctrl_state_reg <= ST_SETUP;
                            end
                        end
                        FUNC_B4_DN: begin
                            if (ctrl_state_reg == ST_SETUP) begin
                                press_start_reg     <= tick_count_reg;
                                ctrl_state_reg      <= ST_COOK;
                                time_left_reg       <= cook_time_reg;
                                seconds_elapsed_reg <= '0;
                                led_pattern_reg     <= '1;
                            end else if (ctrl_state_reg == ST_COOK) begin
                                press_start_reg <= tick_count_reg;
                                ctrl_state_reg  <= ST_RESETP;
                            end
                        end
                        FUNC_B4_UP: begin
                            if (ctrl_state_reg == ST_RESETP) begin
                                ctrl_state_reg <= ST_COOK;
                            end
                        end
                        default: ;
                    endcase
                end
                SEQ_TPS: begin
                    if (div_rsp.done) begin
                        if (div_rsp.remainder == '0) begin
                            // second boundary
                            seconds_elapsed_reg <= seconds_elapsed_reg + 16'd1;
                            if (tl_dec == 9'd0) begin
                                time_left_reg   <= cook_time_reg;
                                ctrl_state_reg  <= ST_SETUP;
                                led_pattern_reg <= '0;
                                seq_reg         <= SEQ_OUT;
                            end else begin
                                time_left_reg <= tl_dec;
                                if (per_q == 9'd0) begin
                                    led_pattern_reg <= led_pattern_reg << 1;
                                    seq_reg         <= SEQ_OUT;
                                end else begin
                                    seq_reg <= SEQ_ELAP;
                                end
                            end
                        end else begin
                            seq_reg <= SEQ_OUT;
                        end
                    end
                end
                SEQ_ELAP: begin
                    if (div_rsp.done) begin
                        if (div_rsp.remainder == '0) begin
                            led_pattern_reg <= led_pattern_reg << 1;
                        end
                        seq_reg <= SEQ_OUT;
                    end
                end
                SEQ_OUT: begin
                    if (out_free) begin
                        seq_reg <= SEQ_IDLE;
                    end
                end
                default: seq_reg <= SEQ_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (seq_reg == SEQ_OUT && out_free) begin
            m_oven_state_reg     <= ctrl_state_reg;
            m_cook_mode_reg      <= mode_reg;
            m_adjusting_temp_reg <= temp_select_reg;
            m_set_time_s_reg     <= cook_time_reg;
            m_remaining_s_reg    <= time_left_reg;
            m_temperature_f_reg  <= temp_now;
            m_heater_on_reg      <= heating;
            m_led_bar_reg        <= led_ext[7:0];
        end
    end

    assign s_ready          = (seq_reg == SEQ_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_oven_state     = m_oven_state_reg;
    assign m_cook_mode      = m_cook_mode_reg;
    assign m_adjusting_temp = m_adjusting_temp_reg;
    assign m_set_time_s     = m_set_time_s_reg;
    assign m_remaining_s    = m_remaining_s_reg;
    assign m_temperature_f  = m_temperature_f_reg;
    assign m_heater_on      = m_heater_on_reg;
    assign m_led_bar        = m_led_bar_reg;

    // lit LEDs only ever exist during a cook or a pending cancel
    a_led_only_heating: assert property (@(posedge aclk) disable iff (!aresetn)
        led_pattern_reg != '0 |-> (ctrl_state_reg == ST_COOK || ctrl_state_reg == ST_RESETP))
        else $error("LED pattern lit outside cooking");

    // one request at a time
    a_single_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while busy");

    // divider results arrive only where the sequencer waits for them
    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (seq_reg == SEQ_TPS || seq_reg == SEQ_ELAP))
        else $error("unexpected divider completion");

    // a result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready && seq_reg == SEQ_OUT |=> seq_reg == SEQ_OUT)
        else $error("result register overwritten");

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for oven_cook_timer_controller: directed and random event
// requests with idle gaps, a built-in predictor of the controller and an in-order check.
// Depends on octc_pkg and the RTL of the block.
module testbench;
    import octc_pkg::*;

    typedef struct {
        logic [2:0] func;
        logic [9:0] knob;
    } oven_req_t;

    typedef struct packed {
        logic [1:0]  oven_state;
        logic [1:0]  cook_mode;
        logic        adjusting;
        logic [8:0]  set_time;
        logic [8:0]  remaining;
        logic [10:0] temp;
        logic        heater;
        logic [7:0]  leds;
    } oven_status_t;

    typedef enum {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_style_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_TPS;
    logic [9:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_func = FUNC_TICK;
    logic [9:0]  s_knob_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_oven_state;
    logic [1:0]  m_cook_mode;
    logic        m_adjusting_temp;
    logic [8:0]  m_set_time_s;
    logic [8:0]  m_remaining_s;
    logic [10:0] m_temperature_f;
    logic        m_heater_on;
    logic [7:0]  m_led_bar;

    oven_cook_timer_controller dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_knob_value    (s_knob_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_oven_state    (m_oven_state),
        .m_cook_mode     (m_cook_mode),
        .m_adjusting_temp(m_adjusting_temp),
        .m_set_time_s    (m_set_time_s),
        .m_remaining_s   (m_remaining_s),
        .m_temperature_f (m_temperature_f),
        .m_heater_on     (m_heater_on),
        .m_led_bar       (m_led_bar)
    );

    always #6 aclk = ~aclk;

    // predictor copy of settings and controller state
    logic [7:0]  cfg_tps, cfg_long;
    logic [9:0]  cfg_bake_ofs, cfg_broil;
    logic [1:0]  oven_st, cook_mode;
    logic        temp_adjust;
    logic [8:0]  set_time, time_left_s;
    logic [7:0]  knob_deg;
    logic [15:0] tick_cnt, press_mark, secs_run;
    logic [7:0]  leds;

    oven_req_t    pending_events[$];
    oven_status_t expected_status[$];
    idle_style_t  idle_style = IDLE_FULL;
    int planned = 0;
    int errors = 0;
    int results_seen = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    int holds_done = 0;
    logic req_taken = 1'b0;
    logic rsp_taken = 1'b0;

    function automatic oven_status_t oven_advance(input logic [2:0] func, input logic [9:0] knob);
        oven_status_t st;
        logic [15:0] held, per_sec;
        logic [8:0]  per;
        held = 16'd0;
        if (func == FUNC_TICK) begin
            tick_cnt = tick_cnt + 16'd1;
            held = tick_cnt - press_mark;
            per_sec = (cfg_tps == 8'd0) ? 16'd1 : {8'd0, cfg_tps};
            if (oven_st == ST_RESETP && held >= cfg_long) begin
                oven_st = ST_SETUP;
                leds = '0;
            end else if ((oven_st == ST_COOK || oven_st == ST_RESETP) && held % per_sec == 0) begin
                // second boundary
                if (time_left_s != 0)
                    time_left_s = time_left_s - 9'd1;
                secs_run = secs_run + 16'd1;
                if (time_left_s == 0) begin
                    time_left_s = set_time;
                    oven_st = ST_SETUP;
                    leds = '0;
                end else begin
                    per = set_time / 9'(LED_COUNT_DEF);
                    if (per == 0 || secs_run % per == 0)
                        leds = {leds[6:0], 1'b0};
                end
            end
        end else if (func == FUNC_KNOB) begin
            if (!temp_adjust)
                set_time = {1'b0, knob[9:2]} + 9'd1;
            else
                knob_deg = knob[9:2];
        end else if (func == FUNC_B3_DN) begin
            if (oven_st == ST_SETUP) begin
                press_mark = tick_cnt;
                oven_st = ST_SELECT;
            end
        end else if (func == FUNC_B3_UP) begin
            if (oven_st == ST_SELECT) begin
                held = tick_cnt - press_mark;
                if (held < cfg_long)
                    cook_mode = (cook_mode == MODE_BAKE) ? MODE_TOAST :
                                (cook_mode == MODE_TOAST) ? MODE_BROIL : MODE_BAKE;
                else if (cook_mode == MODE_BAKE)
                    temp_adjust = ~temp_adjust;
                oven_st = ST_SETUP;
            end
        end else if (func == FUNC_B4_DN) begin
            if (oven_st == ST_SETUP) begin
                press_mark = tick_cnt;
                oven_st = ST_COOK;
                time_left_s = set_time;
                secs_run = '0;
                leds = '1;
            end else if (oven_st == ST_COOK) begin
                press_mark = tick_cnt;
                oven_st = ST_RESETP;
            end
        end else if (func == FUNC_B4_UP) begin
            if (oven_st == ST_RESETP)
                oven_st = ST_COOK;
        end

        st.oven_state = oven_st;
        st.cook_mode  = cook_mode;
        st.adjusting  = temp_adjust;
        st.set_time   = set_time;
        st.remaining  = time_left_s;
        if (cook_mode == MODE_TOAST)
            st.temp = '0;
        else if (cook_mode == MODE_BROIL)
            st.temp = {1'b0, cfg_broil};
        else
            st.temp = {3'b000, knob_deg} + {1'b0, cfg_bake_ofs};
        st.heater = (oven_st == ST_COOK || oven_st == ST_RESETP);
        st.leds   = leds;
        return st;
    endfunction

    task automatic flag_error(input string what, input int got, input int want);
        errors++;
        $display("ERROR at %0t, result %0d: %s got %0d expected %0d",
                 $time, results_seen, what, got, want);
    endtask

    function automatic int draw_wait();
        case (idle_style)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 14);
            default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 14) : 0;
        endcase
    endfunction

    // request driver
    always @(negedge aclk) begin : drive_req
        oven_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || req_taken) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                s_valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
                nxt = pending_events.pop_front();
                s_valid <= 1'b1;
                s_func <= nxt.func;
                s_knob_value <= nxt.knob;
                send_gap = draw_wait();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver; twice it holds off long enough to back up the input
    always @(negedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rsp_taken) begin
                stall_left = draw_wait();
                if (holds_done < 2 && results_seen >= (holds_done == 0 ? 400 : 1100) &&
                    pending_events.size() >= 10) begin
                    hold_left = 400;
                    holds_done++;
                end
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // predict on each accepted request, check each accepted result
    always @(posedge aclk) begin : watch
        oven_status_t want;
        req_taken <= aresetn && s_valid && s_ready;
        rsp_taken <= aresetn && m_valid && m_ready;
        if (aresetn && s_valid && s_ready)
            expected_status.push_back(oven_advance(s_func, s_knob_value));
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_status.size() == 0) begin
                flag_error("result with no request pending", 0, 0);
            end else begin
                want = expected_status.pop_front();
                if (m_oven_state !== want.oven_state)
                    flag_error("oven_state", int'(m_oven_state), int'(want.oven_state));
                if (m_cook_mode !== want.cook_mode)
                    flag_error("cook_mode", int'(m_cook_mode), int'(want.cook_mode));
                if (m_adjusting_temp !== want.adjusting)
                    flag_error("adjusting_temp", int'(m_adjusting_temp), int'(want.adjusting));
                if (m_set_time_s !== want.set_time)
                    flag_error("set_time_s", int'(m_set_time_s), int'(want.set_time));
                if (m_remaining_s !== want.remaining)
                    flag_error("remaining_s", int'(m_remaining_s), int'(want.remaining));
                if (m_temperature_f !== want.temp)
                    flag_error("temperature_f", int'(m_temperature_f), int'(want.temp));
                if (m_heater_on !== want.heater)
                    flag_error("heater_on", int'(m_heater_on), int'(want.heater));
                if (m_led_bar !== want.leds)
                    flag_error("led_bar", int'(m_led_bar), int'(want.leds));
            end
        end
    end

    function automatic void queue_event(input logic [2:0] func, input logic [9:0] knob);
        oven_req_t r;
        r.func = func;
        r.knob = knob;
        pending_events.push_back(r);
        if (func <= FUNC_B4_UP)
            planned++;
    endfunction

    // any converter reading, mostly for events that ignore it
    function automatic logic [9:0] rand_knob();
        return 10'($urandom_range(0, 1023));
    endfunction

    function automatic void queue_ticks(input int n);
        repeat (n) queue_event(FUNC_TICK, rand_knob());
    endfunction

    // mostly short cook times so that cooks run to the end
    function automatic logic [9:0] draw_knob();
        return ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023)) :
                                             10'($urandom_range(0, 63));
    endfunction

    // hold length around the long-press threshold
    function automatic int hold_ticks();
        if (cfg_long == 0)
            return $urandom_range(0, 3);
        case ($urandom_range(0, 2))
            0:       return $urandom_range(0, cfg_long - 1);
            1:       return int'(cfg_long);
            default: return int'(cfg_long) + int'($urandom_range(1, 2));
        endcase
    endfunction

    function automatic void plan_events(input int budget);
        int start_cnt, pick;
        logic [2:0] f;
        start_cnt = planned;
        while (planned - start_cnt < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                queue_event(FUNC_KNOB, draw_knob());
            end else if (pick < 35) begin
                queue_event(FUNC_B3_DN, rand_knob());
                queue_ticks(hold_ticks());
                queue_event(FUNC_B3_UP, rand_knob());
            end else if (pick < 75) begin
                queue_event(FUNC_B4_DN, rand_knob());
                queue_ticks($urandom_range(1, 48));
                if ($urandom_range(0, 3) == 0) begin
                    queue_event(FUNC_B4_DN, rand_knob());
                    queue_ticks(hold_ticks());
                    queue_event(FUNC_B4_UP, rand_knob());
                    queue_ticks($urandom_range(0, 24));
                end
            end else if (pick < 90) begin
                // cancel attempt
                queue_event(FUNC_B4_DN, rand_knob());
                queue_ticks(hold_ticks());
                queue_event(FUNC_B4_UP, rand_knob());
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    f = 3'($urandom_range(0, 7));
                    queue_event(f, rand_knob());
                end
            end
        end
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_TPS:        cfg_tps = value[7:0];
            CFG_LONG_PRESS: cfg_long = value[7:0];
            CFG_BAKE_OFS:   cfg_bake_ofs = value;
            CFG_BROIL_TEMP: cfg_broil = value;
        endcase
    endtask

    // all requests sent and answered, then room for a slow second-boundary tick
    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_events.size() != 0 || s_valid || expected_status.size() != 0);
        repeat (64) @(posedge aclk);
    endtask

    task automatic run_phase(input int tps, input int lp, input int ofs, input int broil,
                             input idle_style_t style, input int budget);
        write_reg(CFG_TPS, 10'(tps));
        write_reg(CFG_LONG_PRESS, 10'(lp));
        write_reg(CFG_BAKE_OFS, 10'(ofs));
        write_reg(CFG_BROIL_TEMP, 10'(broil));
        idle_style = style;
        plan_events(budget);
        wait_drained();
    endtask

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        cfg_tps = 8'd5;
        cfg_long = 8'd5;
        cfg_bake_ofs = 10'd300;
        cfg_broil = 10'd500;
        oven_st = ST_SETUP;
        cook_mode = MODE_BAKE;
        temp_adjust = 1'b0;
        set_time = 9'd1;
        knob_deg = 8'd50;
        time_left_s = 9'd1;
        tick_cnt = '0;
        press_mark = '0;
        secs_run = '0;
        leds = '0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: knob extremes, mode cycle, long press at the threshold,
        // ignored codes and buttons, start, cancel hold and release
        queue_event(FUNC_KNOB, 10'd0);
        queue_event(FUNC_TICK, 10'h3ff);
        queue_event(FUNC_KNOB, 10'h3ff);
        repeat (3) begin
            queue_event(FUNC_B3_DN, 10'd0);
            queue_event(FUNC_B3_UP, 10'h3ff);
        end
        queue_event(FUNC_B3_DN, 10'd0);
        queue_ticks(5);
        queue_event(FUNC_B3_UP, 10'd0);
        queue_event(FUNC_KNOB, 10'h3ff);
        queue_event(3'd6, 10'h155);
        queue_event(3'd7, 10'h2aa);
        queue_event(FUNC_B4_UP, 10'd0);
        queue_event(FUNC_KNOB, 10'd3);
        queue_event(FUNC_B4_DN, 10'd0);
        queue_event(FUNC_B4_DN, 10'd0);
        queue_event(FUNC_B4_UP, 10'd0);
        queue_event(FUNC_B3_DN, 10'd0);
        wait_drained();

        run_phase(1, 1, 0, 0, IDLE_FULL, 200);
        run_phase(0, 0, 1023, 1023, IDLE_NONE, 180);
        run_phase(2, 3, $urandom_range(0, 1023), $urandom_range(0, 1023), IDLE_SPARSE, 200);
        run_phase(255, 255, $urandom_range(0, 1023), $urandom_range(0, 1023), IDLE_FULL, 300);
        run_phase(3, 6, $urandom_range(0, 1023), $urandom_range(0, 1023), IDLE_FULL, 200);
        run_phase(1, 2, $urandom_range(0, 1023), $urandom_range(0, 1023), IDLE_SPARSE, 180);
        run_phase($urandom_range(1, 4), $urandom_range(1, 10), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), IDLE_FULL, 200);
        run_phase(5, 5, 300, 500, IDLE_NONE, 170);

        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
